[src/stl_pkg.sv]
package stl_pkg;

  localparam int unsigned KindWidth = 5;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned ValueWidth = 31;
  localparam int unsigned PrefixWidth = 48;

  localparam logic [3:0] ModeIdle = 4'd0;
  localparam logic [3:0] ModeName = 4'd1;
  localparam logic [3:0] ModeNumber = 4'd2;
  localparam logic [3:0] ModeString = 4'd3;
  localparam logic [3:0] ModePend = 4'd4;
  localparam logic [3:0] ModeComment = 4'd5;
  localparam logic [3:0] ModeStar = 4'd6;
  localparam logic [3:0] ModeHalt = 4'd7;

  localparam logic [4:0] KindEqEq = 5'd16;
  localparam logic [4:0] KindAndAnd = 5'd17;
  localparam logic [4:0] KindOrOr = 5'd18;
  localparam logic [4:0] KindString = 5'd19;
  localparam logic [4:0] KindNumber = 5'd20;
  localparam logic [4:0] KindName = 5'd21;
  localparam logic [4:0] KindIf = 5'd22;
  localparam logic [4:0] KindElse = 5'd23;
  localparam logic [4:0] KindFunc = 5'd24;
  localparam logic [4:0] KindInt = 5'd25;
  localparam logic [4:0] KindFloat = 5'd26;
  localparam logic [4:0] KindStrKw = 5'd27;
  localparam logic [4:0] KindError = 5'd28;
  localparam logic [4:0] KindEnd = 5'd29;

  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [30:0] value;
    logic        saturated;
  } token_t;

  typedef struct packed {
    logic   [1:0] count;
    token_t [2:0] tok;
  } result_t;

  function automatic logic [5:0] symbol_kind(input logic [7:0] c);
    logic [5:0] k;
    k = 6'h20;
    unique case (c)
      8'h2B: k = 6'd0;
      8'h2D: k = 6'd1;
      8'h2F: k = 6'd2;
      8'h2A: k = 6'd3;
      8'h3D: k = 6'd4;
      8'h26: k = 6'd5;
      8'h7C: k = 6'd6;
      8'h2E: k = 6'd7;
      8'h2C: k = 6'd8;
      8'h3B: k = 6'd9;
      8'h28: k = 6'd10;
      8'h29: k = 6'd11;
      8'h5B: k = 6'd12;
      8'h5D: k = 6'd13;
      8'h7B: k = 6'd14;
      8'h7D: k = 6'd15;
      default: k = 6'h20;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] keyword_kind(input logic [15:0] len,
                                              input logic [47:0] p);
    logic [4:0] k;
    k = KindName;
    if (len == 16'd2 && p == 48'h6966) k = KindIf;
    else if (len == 16'd4 && p == 48'h656C7365) k = KindElse;
    else if (len == 16'd3 && p == 48'h616E64) k = KindAndAnd;
    else if (len == 16'd2 && p == 48'h6F72) k = KindOrOr;
    else if (len == 16'd4 && p == 48'h66756E63) k = KindFunc;
    else if (len == 16'd3 && p == 48'h696E74) k = KindInt;
    else if (len == 16'd5 && p == 48'h666C6F6174) k = KindFloat;
    else if (len == 16'd6 && p == 48'h737472696E67) k = KindStrKw;
    return k;
  endfunction

endpackage

[src/stl_core.sv]
module stl_core #(
  parameter int unsigned LINE_BITS = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           char_i,
  input  logic                 eoi_i,
  output stl_pkg::result_t     result_o
);

  localparam logic [LINE_BITS-1:0] LineCap = '1;
  localparam logic [COLUMN_BITS-1:0] ColCap = '1;

  logic [3:0]             mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [15:0]            run_q, run_d;
  logic [47:0]            prefix_q, prefix_d;
  logic [30:0]            acc_q, acc_d;
  logic                   ovf_q, ovf_d;

  stl_pkg::result_t res;

  function automatic logic [15:0] cap_line(input logic [LINE_BITS-1:0] l);
    logic [LINE_BITS:0] v;
    v = {1'b0, l} + 1'b1;
    if (v > (LINE_BITS+1)'(LineCap)) v = (LINE_BITS+1)'(LineCap);
    if (v > (LINE_BITS+1)'(16'hFFFF)) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [15:0] cap_col(input logic [COLUMN_BITS:0] c);
    logic [COLUMN_BITS:0] v;
    v = c;
    if (v > (COLUMN_BITS+1)'(ColCap)) v = (COLUMN_BITS+1)'(ColCap);
    if (v > (COLUMN_BITS+1)'(16'hFFFF)) return 16'hFFFF;
    return 16'(v);
  endfunction

  always_comb begin
    logic cont;
    logic is_letter, is_digit, is_blank, is_dbl, pend_dbl;
    logic [5:0] sk;
    logic [34:0] prod;
    logic [1:0] n;
    stl_pkg::token_t t;
    mode_d = mode_q;
    pend_d = pend_q;
    line_d = line_q;
    col_d = col_q;
    run_d = run_q;
    prefix_d = prefix_q;
    acc_d = acc_q;
    ovf_d = ovf_q;
    n = 2'd0;
    res = '0;
    cont = 1'b0;
    is_letter = (char_i >= 8'h61 && char_i <= 8'h7A) || (char_i >= 8'h41 && char_i <= 8'h5A);
    is_digit = char_i >= 8'h30 && char_i <= 8'h39;
    is_blank = char_i == 8'h20 || (char_i >= 8'd9 && char_i <= 8'd13);
    is_dbl = char_i == 8'h3D || char_i == 8'h26 || char_i == 8'h7C;
    pend_dbl = pend_q == 8'h3D || pend_q == 8'h26 || pend_q == 8'h7C;
    sk = stl_pkg::symbol_kind(char_i);
    prod = {acc_q, 3'b0} + {2'b0, acc_q, 1'b0} + 35'(char_i - 8'h30);
    t = '0;

    if (mode_q != stl_pkg::ModeHalt) begin
      unique case (mode_q)
        stl_pkg::ModeString: begin
          cont = 1'b1;
          if (col_q != ColCap) col_d = col_q + 1'b1;
          if (char_i == 8'h22) begin
            t.kind = stl_pkg::KindString;
            t.line = cap_line(line_q);
            t.column = cap_col({1'b0, col_d});
            t.length = run_q;
            res.tok[n] = t;
            n = n + 1'b1;
            mode_d = stl_pkg::ModeIdle;
          end else if (run_q != 16'hFFFF) begin
            run_d = run_q + 1'b1;
          end
        end
        stl_pkg::ModeComment, stl_pkg::ModeStar: begin
          cont = 1'b1;
          if (char_i == 8'h0A) begin
            if (line_q != LineCap) line_d = line_q + 1'b1;
            col_d = '0;
            mode_d = stl_pkg::ModeComment;
          end else begin
            if (col_q != ColCap) col_d = col_q + 1'b1;
            if (mode_q == stl_pkg::ModeStar && char_i == 8'h2F) mode_d = stl_pkg::ModeIdle;
            else if (char_i == 8'h2A) mode_d = stl_pkg::ModeStar;
            else mode_d = stl_pkg::ModeComment;
          end
        end
        stl_pkg::ModeName: begin
          if (is_letter) begin
            cont = 1'b1;
            if (col_q != ColCap) col_d = col_q + 1'b1;
            if (run_q < 16'd6) prefix_d = {prefix_q[39:0], char_i};
            if (run_q != 16'hFFFF) run_d = run_q + 1'b1;
          end
        end
        stl_pkg::ModeNumber: begin
          if (is_digit) begin
            cont = 1'b1;
            if (col_q != ColCap) col_d = col_q + 1'b1;
            if (ovf_q || prod > 35'(stl_pkg::NumMax)) begin
              acc_d = stl_pkg::NumMax;
              ovf_d = 1'b1;
            end else begin
              acc_d = prod[30:0];
            end
            if (run_q != 16'hFFFF) run_d = run_q + 1'b1;
          end
        end
        stl_pkg::ModePend: begin
          if (pend_q == 8'h2F && char_i == 8'h2A) begin
            cont = 1'b1;
            if (col_q != ColCap) col_d = col_q + 1'b1;
            mode_d = stl_pkg::ModeComment;
          end else if (pend_dbl && char_i == pend_q) begin
            cont = 1'b1;
            if (col_q != ColCap) col_d = col_q + 1'b1;
            t.kind = (char_i == 8'h3D) ? stl_pkg::KindEqEq :
                     (char_i == 8'h26) ? stl_pkg::KindAndAnd : stl_pkg::KindOrOr;
            t.line = cap_line(line_q);
            t.column = cap_col({1'b0, col_d});
            t.length = 16'd2;
            res.tok[n] = t;
            n = n + 1'b1;
            mode_d = stl_pkg::ModeIdle;
          end
        end
        default: ;
      endcase

      if (!cont) begin
        // Flush the token in progress before the byte starts a new one.
        t = '0;
        t.line = cap_line(line_q);
        t.column = cap_col({1'b0, col_q});
        if (mode_q == stl_pkg::ModeName) begin
          t.kind = stl_pkg::keyword_kind(run_q, prefix_q);
          t.length = run_q;
          res.tok[n] = t;
          n = n + 1'b1;
        end else if (mode_q == stl_pkg::ModeNumber) begin
          t.kind = stl_pkg::KindNumber;
          t.length = run_q;
          t.value = acc_q;
          t.saturated = ovf_q;
          res.tok[n] = t;
          n = n + 1'b1;
        end else if (mode_q == stl_pkg::ModePend) begin
          t.kind = 5'(stl_pkg::symbol_kind(pend_q));
          t.length = 16'd1;
          res.tok[n] = t;
          n = n + 1'b1;
        end
        mode_d = stl_pkg::ModeIdle;

        if (char_i == 8'h0A) begin
          if (line_q != LineCap) line_d = line_q + 1'b1;
          col_d = '0;
        end else begin
          if (col_q != ColCap) col_d = col_q + 1'b1;
          t = '0;
          t.line = cap_line(line_q);
          t.column = cap_col({1'b0, col_d});
          t.length = 16'd1;
          if (char_i == 8'h2F || is_dbl) begin
            mode_d = stl_pkg::ModePend;
            pend_d = char_i;
          end else if (!sk[5]) begin
            t.kind = sk[4:0];
            res.tok[n] = t;
            n = n + 1'b1;
          end else if (char_i == 8'h22) begin
            mode_d = stl_pkg::ModeString;
            run_d = '0;
          end else if (is_digit) begin
            mode_d = stl_pkg::ModeNumber;
            acc_d = 31'(char_i - 8'h30);
            ovf_d = 1'b0;
            run_d = 16'd1;
          end else if (is_letter) begin
            mode_d = stl_pkg::ModeName;
            prefix_d = {40'b0, char_i};
            run_d = 16'd1;
          end else if (!is_blank) begin
            t.kind = stl_pkg::KindError;
            res.tok[n] = t;
            n = n + 1'b1;
            mode_d = stl_pkg::ModeHalt;
          end
        end
      end
    end

    if (eoi_i) begin
      t = '0;
      t.line = cap_line(line_d);
      t.column = cap_col({1'b0, col_d});
      if (mode_d == stl_pkg::ModeName) begin
        t.kind = stl_pkg::keyword_kind(run_d, prefix_d);
        t.length = run_d;
        res.tok[n] = t;
        n = n + 1'b1;
      end else if (mode_d == stl_pkg::ModeNumber) begin
        t.kind = stl_pkg::KindNumber;
        t.length = run_d;
        t.value = acc_d;
        t.saturated = ovf_d;
        res.tok[n] = t;
        n = n + 1'b1;
      end else if (mode_d == stl_pkg::ModeString) begin
        t.kind = stl_pkg::KindString;
        t.length = run_d;
        res.tok[n] = t;
        n = n + 1'b1;
      end else if (mode_d == stl_pkg::ModePend) begin
        t.kind = 5'(stl_pkg::symbol_kind(pend_d));
        t.length = 16'd1;
        res.tok[n] = t;
        n = n + 1'b1;
      end
      if (n != 2'd3) begin
        t = '0;
        t.kind = stl_pkg::KindEnd;
        t.line = cap_line(line_d);
        t.column = cap_col({1'b0, col_d} + 1'b1);
        res.tok[n] = t;
        n = n + 1'b1;
      end
      mode_d = stl_pkg::ModeIdle;
      pend_d = '0;
      line_d = '0;
      col_d = '0;
      run_d = '0;
      prefix_d = '0;
      acc_d = '0;
      ovf_d = 1'b0;
    end
    res.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stl_pkg::ModeIdle;
      pend_q <= '0;
      line_q <= '0;
      col_q <= '0;
      run_q <= '0;
      prefix_q <= '0;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      line_q <= line_d;
      col_q <= col_d;
      run_q <= run_d;
      prefix_q <= prefix_d;
      acc_q <= acc_d;
      ovf_q <= ovf_d;
    end
  end

  assign result_o = res;

endmodule

[src/stl_out.sv]
module stl_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  stl_pkg::result_t  result_i,
  output logic              ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [87:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  stl_pkg::result_t buf_q;
  logic [1:0] idx_q;
  logic [1:0] cnt_q;
  logic fire, done;
  stl_pkg::token_t t;

  assign fire = m_axis_tvalid && m_axis_tready;
  assign done = fire && (idx_q + 2'd1 == cnt_q);
  assign ready_o = (cnt_q == 2'd0) || done;
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign t = buf_q.tok[idx_q];
  assign m_axis_tlast = idx_q + 2'd1 == cnt_q;
  assign m_axis_tdata = {3'b0, t.saturated, t.value, t.length, t.column, t.line, t.kind};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= result_i.count;
      idx_q <= '0;
    end else if (done) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= result_i;
  end

endmodule

[src/source_text_lexer_top.sv]
// One source byte is taken per cycle when the output side keeps up and no byte
// yields more than one token; each byte yields zero to three tokens, which leave
// one per cycle while m_axis_tready is high, with tlast on the last token of that
// byte, and input is held off until the previous byte's tokens have gone.
module source_text_lexer_top #(
  parameter int unsigned LINE_BITS = 16,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // character [7:0]
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // token_kind [4:0], line_number [20:5], column_number [36:21],
  // token_length [52:37], number_value [83:53], value_saturated [84], zero fill above
  output logic [87:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  stl_pkg::result_t res;
  logic ready, step;

  assign step = s_axis_tvalid && ready;
  assign s_axis_tready = ready;

  stl_core #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_core (
    .clk_i, .rst_ni, .step_i(step), .char_i(s_axis_tdata), .eoi_i(s_axis_tlast),
    .result_o(res)
  );

  stl_out u_out (
    .clk_i, .rst_ni, .load_i(step), .result_i(res), .ready_o(ready),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

endmodule

[bench/source_text_lexer_checker.sv]
module source_text_lexer_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  logic [7:0]   in_char_i,
  input  logic         in_end_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic [87:0]  out_data_i,
  input  logic         out_last_i,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam string SymbolSet = "+-/*=&|.,;()[]{}";
  localparam int ExpDepth = 64;

  typedef struct {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [30:0] value;
    logic        saturated;
    logic        last;
  } token_rec_t;

  token_rec_t exp_tok[ExpDepth];
  int         exp_wr = 0;
  int         exp_rd = 0;
  token_rec_t step_tok[3];
  int         step_cnt = 0;
  int         err_count = 0;

  logic [3:0]  mode;
  logic [7:0]  held_symbol;
  logic [15:0] line_cnt;
  logic [15:0] col_cnt;
  logic [15:0] run_len;
  logic [47:0] letters;
  logic [30:0] accum;
  logic        overflow;

  assign pending_o = exp_wr - exp_rd;
  assign errors_o = err_count;

  function automatic int symbol_index(input logic [7:0] c);
    for (int i = 0; i < 16; i++) begin
      if (SymbolSet[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_doubling(input logic [7:0] c);
    return c == "=" || c == "&" || c == "|";
  endfunction

  function automatic logic [4:0] word_kind();
    if (run_len == 2 && letters == 48'("if")) return stl_pkg::KindIf;
    if (run_len == 4 && letters == 48'("else")) return stl_pkg::KindElse;
    if (run_len == 3 && letters == 48'("and")) return stl_pkg::KindAndAnd;
    if (run_len == 2 && letters == 48'("or")) return stl_pkg::KindOrOr;
    if (run_len == 4 && letters == 48'("func")) return stl_pkg::KindFunc;
    if (run_len == 3 && letters == 48'("int")) return stl_pkg::KindInt;
    if (run_len == 5 && letters == 48'("float")) return stl_pkg::KindFloat;
    if (run_len == 6 && letters == 48'("string")) return stl_pkg::KindStrKw;
    return stl_pkg::KindName;
  endfunction

  function automatic void push_token(input logic [4:0] kind, input logic [16:0] col,
                                     input logic [15:0] len, input logic [30:0] val,
                                     input logic sat);
    token_rec_t t;
    logic [16:0] ln;
    if (step_cnt >= 3) return;
    ln = {1'b0, line_cnt} + 17'd1;
    t.kind = kind;
    t.line = ln > 17'd65535 ? 16'hFFFF : ln[15:0];
    t.column = col > 17'd65535 ? 16'hFFFF : col[15:0];
    t.length = len;
    t.value = val;
    t.saturated = sat;
    t.last = 1'b0;
    step_tok[step_cnt] = t;
    step_cnt++;
  endfunction

  function automatic void step_column();
    if (col_cnt != 16'hFFFF) col_cnt++;
  endfunction

  function automatic void step_line();
    if (line_cnt != 16'hFFFF) line_cnt++;
    col_cnt = '0;
  endfunction

  function automatic void grow_run();
    if (run_len != 16'hFFFF) run_len++;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    logic [34:0] v;
    v = accum * 35'd10 + 35'(c - "0");
    if (overflow || v > 35'(stl_pkg::NumMax)) begin
      accum = stl_pkg::NumMax;
      overflow = 1'b1;
    end else begin
      accum = v[30:0];
    end
  endfunction

  function automatic void flush_pending();
    case (mode)
      stl_pkg::ModeName: push_token(word_kind(), {1'b0, col_cnt}, run_len, '0, 1'b0);
      stl_pkg::ModeNumber: push_token(stl_pkg::KindNumber, {1'b0, col_cnt}, run_len, accum,
                                      overflow);
      stl_pkg::ModeString: push_token(stl_pkg::KindString, {1'b0, col_cnt}, run_len, '0,
                                      1'b0);
      stl_pkg::ModePend: push_token(5'(symbol_index(held_symbol)), {1'b0, col_cnt}, 16'd1,
                                    '0, 1'b0);
      default: ;
    endcase
    if (mode != stl_pkg::ModeHalt) mode = stl_pkg::ModeIdle;
  endfunction

  function automatic bit extend_token(input logic [7:0] c);
    case (mode)
      stl_pkg::ModeString: begin
        step_column();
        if (c == "\"") begin
          push_token(stl_pkg::KindString, {1'b0, col_cnt}, run_len, '0, 1'b0);
          mode = stl_pkg::ModeIdle;
        end else begin
          grow_run();
        end
        return 1'b1;
      end
      stl_pkg::ModeComment, stl_pkg::ModeStar: begin
        if (c == "\n") begin
          step_line();
          mode = stl_pkg::ModeComment;
          return 1'b1;
        end
        step_column();
        if (mode == stl_pkg::ModeStar && c == "/") mode = stl_pkg::ModeIdle;
        else mode = (c == "*") ? stl_pkg::ModeStar : stl_pkg::ModeComment;
        return 1'b1;
      end
      stl_pkg::ModeName: begin
        if (is_letter(c)) begin
          step_column();
          if (run_len < 6) letters = {letters[39:0], c};
          grow_run();
          return 1'b1;
        end
      end
      stl_pkg::ModeNumber: begin
        if (is_digit(c)) begin
          step_column();
          take_digit(c);
          grow_run();
          return 1'b1;
        end
      end
      stl_pkg::ModePend: begin
        if (held_symbol == "/" && c == "*") begin
          step_column();
          mode = stl_pkg::ModeComment;
          return 1'b1;
        end
        if (is_doubling(held_symbol) && c == held_symbol) begin
          step_column();
          push_token(c == "=" ? stl_pkg::KindEqEq :
                     (c == "&" ? stl_pkg::KindAndAnd : stl_pkg::KindOrOr),
                     {1'b0, col_cnt}, 16'd2, '0, 1'b0);
          mode = stl_pkg::ModeIdle;
          return 1'b1;
        end
      end
      default: return 1'b0;
    endcase
    flush_pending();
    return 1'b0;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    int k;
    if (c == "\n") begin
      step_line();
      return;
    end
    step_column();
    k = symbol_index(c);
    if (c == "/" || is_doubling(c)) begin
      mode = stl_pkg::ModePend;
      held_symbol = c;
    end else if (k >= 0) begin
      push_token(5'(k), {1'b0, col_cnt}, 16'd1, '0, 1'b0);
    end else if (c == "\"") begin
      mode = stl_pkg::ModeString;
      run_len = '0;
    end else if (is_digit(c)) begin
      mode = stl_pkg::ModeNumber;
      accum = '0;
      overflow = 1'b0;
      take_digit(c);
      run_len = 16'd1;
    end else if (is_letter(c)) begin
      mode = stl_pkg::ModeName;
      letters = 48'(c);
      run_len = 16'd1;
    end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
      push_token(stl_pkg::KindError, {1'b0, col_cnt}, 16'd1, '0, 1'b0);
      mode = stl_pkg::ModeHalt;
    end
  endfunction

  function automatic void clear_state();
    mode = stl_pkg::ModeIdle;
    held_symbol = '0;
    line_cnt = '0;
    col_cnt = '0;
    run_len = '0;
    letters = '0;
    accum = '0;
    overflow = 1'b0;
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic eoi);
    step_cnt = 0;
    if (mode != stl_pkg::ModeHalt && !extend_token(c)) open_token(c);
    if (eoi) begin
      flush_pending();
      push_token(stl_pkg::KindEnd, {1'b0, col_cnt} + 17'd1, '0, '0, 1'b0);
      clear_state();
    end
    if (step_cnt > 0) step_tok[step_cnt - 1].last = 1'b1;
    for (int i = 0; i < step_cnt; i++) begin
      exp_tok[exp_wr % ExpDepth] = step_tok[i];
      exp_wr++;
    end
  endfunction

  task automatic compare_field(input string name, input logic [30:0] exp_v,
                               input logic [30:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  initial begin
    clear_state();
  end

  always @(posedge clk_i) begin
    token_rec_t e;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (exp_wr == exp_rd) begin
          $error("token transfer with no token expected: %h", out_data_i);
          err_count++;
        end else begin
          e = exp_tok[exp_rd % ExpDepth];
          exp_rd++;
          compare_field("token_kind", 31'(e.kind), 31'(out_data_i[4:0]));
          compare_field("line_number", 31'(e.line), 31'(out_data_i[20:5]));
          compare_field("column_number", 31'(e.column), 31'(out_data_i[36:21]));
          compare_field("token_length", 31'(e.length), 31'(out_data_i[52:37]));
          compare_field("number_value", e.value, out_data_i[83:53]);
          compare_field("value_saturated", 31'(e.saturated), 31'(out_data_i[84]));
          compare_field("zero_fill", 31'd0, 31'(out_data_i[87:85] != 3'd0));
          compare_field("last_result", 31'(e.last), 31'(out_last_i));
        end
      end
      if (in_valid_i && in_ready_i) lex_byte(in_char_i, in_end_i);
    end
  end

endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam string SymbolSet = "+-/*=&|.,;()[]{}";

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tlast;
  int           error_count;
  int           tokens_pending;

  logic [7:0] source_bytes[512];
  bit         source_ends[512];
  int         source_len = 0;
  string      keyword_list[8] = '{"if", "else", "and", "or", "func", "int", "float", "string"};

  source_text_lexer_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  source_text_lexer_checker u_checker (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_i(s_axis_tready),
    .in_char_i(s_axis_tdata),
    .in_end_i(s_axis_tlast),
    .out_valid_i(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_i(m_axis_tdata),
    .out_last_i(m_axis_tlast),
    .errors_o(error_count),
    .pending_o(tokens_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] c);
    source_bytes[source_len] = c;
    source_ends[source_len] = 1'b0;
    source_len++;
  endfunction

  function automatic void add_text(input string s, input bit eoi);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
      source_ends[source_len - 1] = eoi && i == s.len() - 1;
    end
  endfunction

  function automatic void add_random_token();
    int n;
    case ($urandom_range(0, 9))
      0, 1: add_text(keyword_list[$urandom_range(0, 7)], 1'b0);
      2: begin
        n = $urandom_range(1, 8);
        repeat (n) add_byte($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                                 : 8'($urandom_range("A", "Z")));
      end
      3: begin
        n = $urandom_range(1, 12);
        repeat (n) add_byte(8'($urandom_range("0", "9")));
      end
      4: begin
        add_byte("\"");
        n = $urandom_range(0, 6);
        repeat (n) add_byte($urandom_range(0, 7) == 0 ? 8'h0A : 8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) != 0) add_byte("\"");
      end
      5, 6: add_byte(SymbolSet[$urandom_range(0, 15)]);
      7: begin
        add_text("/*", 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) add_byte($urandom_range(0, 3) == 0 ? "*" :
                            ($urandom_range(0, 3) == 0 ? 8'h0A : 8'($urandom_range(32, 126))));
        if ($urandom_range(0, 5) != 0) add_text("*/", 1'b0);
      end
      8: add_byte($urandom_range(0, 2) == 0 ? 8'h0A : ($urandom_range(0, 1) ? " " : 8'h09));
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          add_byte(8'($urandom_range(0, 255)));
          source_ends[source_len - 1] = 1'($urandom_range(0, 1));
        end else begin
          add_byte(" ");
        end
      end
    endcase
    if ($urandom_range(0, 2) != 0) add_byte($urandom_range(0, 4) == 0 ? 8'h0A : " ");
    if ($urandom_range(0, 24) == 0) source_ends[source_len - 1] = 1'b1;
  endfunction

  initial begin
    int burst;
    int stall;
    burst = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (burst == 0) burst = $urandom_range(1, 40) * ($urandom_range(0, 2) == 0 ? -1 : 1);
      stall = burst < 0 ? 0 : $urandom_range(0, 6);
      burst += burst < 0 ? 1 : -1;
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int gap;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    rst_ni = 1'b0;

    add_text("a==&&||/*\n*/\"q\n\"+-*.,;()[]{}", 1'b0);
    add_text(" int\n3000000000 = & | /x", 1'b0);
    add_byte(8'hFF);
    add_text("zz", 1'b1);
    add_text("\"open", 1'b1);
    while (source_len < 210) add_random_token();
    source_ends[source_len - 1] = 1'b1;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < source_len; i++) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      @(negedge clk_i);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= source_bytes[i];
      s_axis_tlast <= source_ends[i];
      do @(posedge clk_i); while (!s_axis_tready);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (tokens_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && tokens_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
